[rtl/core/rsm_pkg.sv]
// shared types, codes and defaults for the reverse-Polish stack machine
package rsm_pkg;

    localparam int STACK_DEPTH_DEF    = 64;
    localparam int VAR_COUNT_DEF      = 256;
    localparam int INDEX_BITS_DEF     = 16;
    localparam int DATA_W             = 32;
    localparam int OUT_INDEX_W        = 16;

    typedef enum logic [4:0] {
        OP_PUSH   = 5'd0,
        OP_LOAD   = 5'd1,
        OP_NOT    = 5'd2,
        OP_OR     = 5'd3,
        OP_AND    = 5'd4,
        OP_GO     = 5'd5,
        OP_FGO    = 5'd6,
        OP_WRITE  = 5'd7,
        OP_READ   = 5'd8,
        OP_ADD    = 5'd9,
        OP_MUL    = 5'd10,
        OP_SUB    = 5'd11,
        OP_DIV    = 5'd12,
        OP_EQ     = 5'd13,
        OP_LT     = 5'd14,
        OP_GT     = 5'd15,
        OP_LE     = 5'd16,
        OP_GE     = 5'd17,
        OP_NE     = 5'd18,
        OP_ASSIGN = 5'd19
    } op_t;

    typedef enum logic [2:0] {
        ERR_OK     = 3'd0,
        ERR_UNDEF  = 3'd1,
        ERR_DIV0   = 3'd2,
        ERR_OPCODE = 3'd3,
        ERR_UNDER  = 3'd4,
        ERR_OVER   = 3'd5,
        ERR_INDEX  = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV_WAIT,
        ST_DIV_COMMIT
    } state_t;

endpackage

[rtl/core/rsm_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module rsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/rsm_div.sv]
// iterative signed divider, one quotient bit per cycle, truncating
module rsm_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rsm_pkg::DATA_W-1:0] dividend,
    input  logic [rsm_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [rsm_pkg::DATA_W-1:0] quotient
);

    localparam int W = rsm_pkg::DATA_W;

    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         quo_reg, quo_next;
    logic [W-1:0]         dvs_reg, dvs_next;
    logic [$clog2(W):0]   cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 neg_reg, neg_next;
    logic                 done_reg, done_next;
    logic [W-1:0]         res_reg, res_next;
    logic [W:0]           trial;
    logic [W-1:0]         shifted;

    // one restoring step
    always_comb begin
        shifted   = {rem_reg[W-2:0], quo_reg[W-1]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend[W-1] ? -dividend : dividend;
            dvs_next  = divisor[W-1] ? -divisor : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[W-2:0], ~trial[W]};
            rem_next = trial[W] ? shifted : trial[W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(W)+1)'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -{quo_reg[W-2:0], ~trial[W]}
                                    : {quo_reg[W-2:0], ~trial[W]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

    // a start never arrives while a division runs
    assert property (@(posedge aclk) disable iff (!aresetn) start |-> !busy_reg)
        else $error("divider started while busy");
    // done follows the last step
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    // done is a single pulse
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |=> !done_reg)
        else $error("divider done held");

endmodule

[rtl/core/rpn_stack_machine_step.sv]
// Reverse-Polish stack machine executing one instruction per input transaction.
// After reset the variable table is swept clear, one entry a cycle, over all
// VARIABLE_COUNT entries, with s_tready low. For an ordinary instruction the
// accept in ST_IDLE issues the stack and variable ram reads, then ST_EXEC
// evaluates and commits into the result register once it is free. A division
// runs the iterative divider for one bit a cycle, waits in ST_DIV_WAIT and
// commits from ST_DIV_COMMIT. The next transaction is taken once the previous
// result is committed; a result waiting on m_tready stalls ST_EXEC and ST_DIV_COMMIT.
module rpn_stack_machine_step #(
    parameter int STACK_DEPTH        = rsm_pkg::STACK_DEPTH_DEF,
    parameter int VARIABLE_COUNT     = rsm_pkg::VAR_COUNT_DEF,
    parameter int PROGRAM_INDEX_BITS = rsm_pkg::INDEX_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[4:0], operand[36:5], current_index[52:37], read_value[84:53]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_index[15:0], write_valid[16], write_value[48:17], error_code[51:49]
    output logic [55:0] m_tdata
);

    localparam int W     = rsm_pkg::DATA_W;
    localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int VAW   = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
    localparam logic [32:0] IDX_MASK = (33'd1 << PROGRAM_INDEX_BITS) - 33'd1;
    localparam logic [W-1:0] VAR_LIMIT = W'(VARIABLE_COUNT);

    rsm_pkg::state_t state_reg, state_next;

    logic [4:0]     op_reg, op_next;
    logic [W-1:0]   operand_reg, operand_next;
    logic [15:0]    cur_reg, cur_next;
    logic [W-1:0]   rd_reg, rd_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [VAW-1:0] clr_reg, clr_next;

    logic           out_valid_reg, out_valid_next;
    logic [15:0]    next_idx_reg, next_idx_next;
    logic           wvalid_reg, wvalid_next;
    logic [W-1:0]   wvalue_reg, wvalue_next;
    logic [2:0]     err_reg, err_next;

    // ram ports
    logic [SAW-1:0] stk_y_addr, stk_x_addr, stk_wr_addr;
    logic [W-1:0]   stk_y, stk_x, stk_wr_data;
    logic           stk_wr_en;
    logic [VAW-1:0] var_rd_addr, var_wr_addr;
    logic [W:0]     var_rd_data, var_wr_data;
    logic           var_wr_en;

    logic           div_start, div_done;
    logic [W-1:0]   div_q;

    // evaluation signals
    logic [1:0]     need;
    logic           push;
    rsm_pkg::err_t  err;
    logic [W-1:0]   res;
    logic [32:0]    nxt;
    logic [32:0]    cur_ext;
    logic           out_free;
    logic           commit;
    logic           is_div;
    logic [SPW-1:0] sp_base;

    // stack reads follow sp_reg; the variable read uses s_tdata while idle, operand_reg after
    always_comb begin
        logic [SPW-1:0] sp1, sp2;
        sp1 = sp_reg - SPW'(1);
        sp2 = sp_reg - SPW'(2);
        stk_y_addr  = sp1[SAW-1:0];
        stk_x_addr  = sp2[SAW-1:0];
        var_rd_addr = (state_reg == rsm_pkg::ST_IDLE) ? s_tdata[5 +: VAW]
                                                      : operand_reg[VAW-1:0];
    end

    rsm_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stk_y (
        .aclk(aclk), .wr_en(stk_wr_en), .wr_addr(stk_wr_addr), .wr_data(stk_wr_data),
        .rd_addr(stk_y_addr), .rd_data(stk_y)
    );

    rsm_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stk_x (
        .aclk(aclk), .wr_en(stk_wr_en), .wr_addr(stk_wr_addr), .wr_data(stk_wr_data),
        .rd_addr(stk_x_addr), .rd_data(stk_x)
    );

    // variable values with the assigned flag in the top bit
    rsm_ram #(.WIDTH(W + 1), .DEPTH(VARIABLE_COUNT)) u_var (
        .aclk(aclk), .wr_en(var_wr_en), .wr_addr(var_wr_addr), .wr_data(var_wr_data),
        .rd_addr(var_rd_addr), .rd_data(var_rd_data)
    );

    rsm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(stk_x), .divisor(stk_y), .done(div_done), .quotient(div_q)
    );

    // instruction evaluation
    always_comb begin
        cur_ext = {17'b0, cur_reg};
        nxt     = (cur_ext + 33'd1) & IDX_MASK;
        push    = 1'b0;
        res     = '0;
        err     = rsm_pkg::ERR_OK;
        case (op_reg)
            rsm_pkg::OP_PUSH, rsm_pkg::OP_LOAD: need = 2'd0;
            rsm_pkg::OP_NOT, rsm_pkg::OP_GO, rsm_pkg::OP_WRITE,
            rsm_pkg::OP_READ: need = 2'd1;
            default: need = 2'd2;
        endcase
        if (op_reg > rsm_pkg::OP_ASSIGN) begin
            err = rsm_pkg::ERR_OPCODE;
        end else if (sp_reg < SPW'(need)) begin
            err = rsm_pkg::ERR_UNDER;
        end else begin
            case (op_reg)
                rsm_pkg::OP_PUSH: begin
                    res = operand_reg; push = 1'b1;
                end
                rsm_pkg::OP_LOAD: begin
                    if (operand_reg >= VAR_LIMIT) err = rsm_pkg::ERR_INDEX;
                    else if (!var_rd_data[W]) err = rsm_pkg::ERR_UNDEF;
                    else begin
                        res = var_rd_data[W-1:0]; push = 1'b1;
                    end
                end
                rsm_pkg::OP_NOT: begin
                    res = W'(stk_y == '0); push = 1'b1;
                end
                rsm_pkg::OP_OR: begin
                    res = W'(stk_x != '0 || stk_y != '0); push = 1'b1;
                end
                rsm_pkg::OP_AND: begin
                    res = W'(stk_x != '0 && stk_y != '0); push = 1'b1;
                end
                rsm_pkg::OP_GO: begin
                    if ({1'b0, stk_y} > IDX_MASK) err = rsm_pkg::ERR_INDEX;
                    else nxt = {1'b0, stk_y};
                end
                rsm_pkg::OP_FGO: begin
                    if (stk_x == '0) begin
                        if ({1'b0, stk_y} > IDX_MASK) err = rsm_pkg::ERR_INDEX;
                        else nxt = {1'b0, stk_y};
                    end
                end
                rsm_pkg::OP_WRITE: ;
                rsm_pkg::OP_READ: begin
                    if (stk_y >= VAR_LIMIT) err = rsm_pkg::ERR_INDEX;
                end
                rsm_pkg::OP_ADD: begin
                    res = stk_x + stk_y; push = 1'b1;
                end
                rsm_pkg::OP_MUL: begin
                    res = stk_x * stk_y; push = 1'b1;
                end
                rsm_pkg::OP_SUB: begin
                    res = stk_x - stk_y; push = 1'b1;
                end
                rsm_pkg::OP_DIV: begin
                    if (stk_y == '0) err = rsm_pkg::ERR_DIV0;
                    else begin
                        res = div_q; push = 1'b1;
                    end
                end
                rsm_pkg::OP_EQ: begin
                    res = W'(stk_x == stk_y); push = 1'b1;
                end
                rsm_pkg::OP_LT: begin
                    res = W'($signed(stk_x) < $signed(stk_y)); push = 1'b1;
                end
                rsm_pkg::OP_GT: begin
                    res = W'($signed(stk_x) > $signed(stk_y)); push = 1'b1;
                end
                rsm_pkg::OP_LE: begin
                    res = W'($signed(stk_x) <= $signed(stk_y)); push = 1'b1;
                end
                rsm_pkg::OP_GE: begin
                    res = W'($signed(stk_x) >= $signed(stk_y)); push = 1'b1;
                end
                rsm_pkg::OP_NE: begin
                    res = W'(stk_x != stk_y); push = 1'b1;
                end
                rsm_pkg::OP_ASSIGN: begin
                    if (stk_x >= VAR_LIMIT) err = rsm_pkg::ERR_INDEX;
                end
                default: err = rsm_pkg::ERR_OPCODE;
            endcase
            if (err == rsm_pkg::ERR_OK && push && (sp_reg - SPW'(need)) >= SPW'(STACK_DEPTH))
                err = rsm_pkg::ERR_OVER;
        end
        if (err != rsm_pkg::ERR_OK) nxt = cur_ext & IDX_MASK;
        sp_base = sp_reg - SPW'(need);
    end

    // control sequencer
    always_comb begin
        out_free       = !out_valid_reg || m_tready;
        is_div         = (op_reg == rsm_pkg::OP_DIV) && (err == rsm_pkg::ERR_OK);
        state_next     = state_reg;
        commit         = 1'b0;
        div_start      = 1'b0;
        s_tready       = 1'b0;
        clr_next       = clr_reg;
        op_next        = op_reg;
        operand_next   = operand_reg;
        cur_next       = cur_reg;
        rd_next        = rd_reg;
        case (state_reg)
            rsm_pkg::ST_CLEAR: begin
                clr_next = clr_reg + VAW'(1);
                if (clr_reg == VAW'(VARIABLE_COUNT - 1)) state_next = rsm_pkg::ST_IDLE;
            end
            rsm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next      = s_tdata[4:0];
                    operand_next = s_tdata[36:5];
                    cur_next     = s_tdata[52:37];
                    rd_next      = s_tdata[84:53];
                    state_next   = rsm_pkg::ST_EXEC;
                end
            end
            rsm_pkg::ST_EXEC: begin
                if (is_div) begin
                    div_start  = 1'b1;
                    state_next = rsm_pkg::ST_DIV_WAIT;
                end else if (out_free) begin
                    commit     = 1'b1;
                    state_next = rsm_pkg::ST_IDLE;
                end
            end
            rsm_pkg::ST_DIV_WAIT: begin
                if (div_done) state_next = rsm_pkg::ST_DIV_COMMIT;
            end
            rsm_pkg::ST_DIV_COMMIT: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = rsm_pkg::ST_IDLE;
                end
            end
            default: state_next = rsm_pkg::ST_IDLE;
        endcase
    end

    // state writes on commit, clearing writes during the sweep, and result register load on commit
    always_comb begin
        logic ok;
        ok             = commit && (err == rsm_pkg::ERR_OK);
        stk_wr_en      = ok && push;
        stk_wr_addr    = sp_base[SAW-1:0];
        stk_wr_data    = res;
        sp_next        = ok ? (sp_base + SPW'(push)) : sp_reg;
        var_wr_en      = 1'b0;
        var_wr_addr    = clr_reg;
        var_wr_data    = '0;
        if (state_reg == rsm_pkg::ST_CLEAR) begin
            var_wr_en = 1'b1;
        end else if (ok && op_reg == rsm_pkg::OP_READ) begin
            var_wr_en   = 1'b1;
            var_wr_addr = stk_y[VAW-1:0];
            var_wr_data = {1'b1, rd_reg};
        end else if (ok && op_reg == rsm_pkg::OP_ASSIGN) begin
            var_wr_en   = 1'b1;
            var_wr_addr = stk_x[VAW-1:0];
            var_wr_data = {1'b1, stk_y};
        end
        out_valid_next = out_valid_reg && !m_tready;
        next_idx_next  = next_idx_reg;
        wvalid_next    = wvalid_reg;
        wvalue_next    = wvalue_reg;
        err_next       = err_reg;
        if (commit) begin
            out_valid_next = 1'b1;
            next_idx_next  = nxt[15:0];
            wvalid_next    = ok && (op_reg == rsm_pkg::OP_WRITE);
            wvalue_next    = (ok && op_reg == rsm_pkg::OP_WRITE) ? stk_y : '0;
            err_next       = err;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rsm_pkg::ST_CLEAR;
            sp_reg        <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg       <= op_next;
        operand_reg  <= operand_next;
        cur_reg      <= cur_next;
        rd_reg       <= rd_next;
        next_idx_reg <= next_idx_next;
        wvalid_reg   <= wvalid_next;
        wvalue_reg   <= wvalue_next;
        err_reg      <= err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, err_reg, wvalue_reg, wvalid_reg, next_idx_reg};

    // stack pointer stays within the stack
    assert property (@(posedge aclk) disable iff (!aresetn) sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    // an error result never carries a write value
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && err_reg != rsm_pkg::ERR_OK |-> !wvalid_reg)
        else $error("write flagged on error");
    // no transaction is taken during the clearing sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rsm_pkg::ST_CLEAR |-> !s_tready)
        else $error("input accepted while clearing");
    // a held result is not overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(m_tdata))
        else $error("pending result lost");

endmodule

[tb/sv/rpn_step_checker.sv]
// checker for the stack machine: predicts each result and compares it with the block output
`timescale 1ns / 1ps
module rpn_step_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);

    localparam int DEPTH = rsm_pkg::STACK_DEPTH_DEF;
    localparam int VARS  = rsm_pkg::VAR_COUNT_DEF;
    localparam int SAW   = $clog2(DEPTH);
    localparam int VAW   = $clog2(VARS);

    typedef struct packed {
        logic [2:0]  err;
        logic [31:0] wvalue;
        logic        wvalid;
        logic [15:0] next;
    } step_result_t;

    logic [31:0]  stack_mem [DEPTH];
    int unsigned  sp;
    logic [31:0]  var_mem [VARS];
    logic         var_set [VARS];
    step_result_t expected_q [$];

    // compute the outcome of one instruction and update the predicted state
    function automatic step_result_t execute_instr(logic [87:0] d);
        logic [4:0]  op;
        logic [31:0] opnd, rd, x, y, res;
        logic [15:0] cur;
        logic [16:0] nxt;
        logic [2:0]  err;
        int unsigned need;
        logic        push, wv;
        logic [31:0] wval;
        step_result_t r;
        op = d[4:0]; opnd = d[36:5]; cur = d[52:37]; rd = d[84:53];
        nxt = {1'b0, cur} + 17'd1;
        err = rsm_pkg::ERR_OK; push = 0; wv = 0; wval = 0; x = 0; y = 0; res = 0;
        if (op <= rsm_pkg::OP_LOAD) need = 0;
        else if (op == rsm_pkg::OP_NOT || op == rsm_pkg::OP_GO ||
                 op == rsm_pkg::OP_WRITE || op == rsm_pkg::OP_READ) need = 1;
        else need = 2;
        if (op > rsm_pkg::OP_ASSIGN) err = rsm_pkg::ERR_OPCODE;
        else if (sp < need) err = rsm_pkg::ERR_UNDER;
        if (err == rsm_pkg::ERR_OK) begin
            if (need >= 1) y = stack_mem[SAW'(sp - 1)];
            if (need >= 2) x = stack_mem[SAW'(sp - 2)];
            case (op)
                rsm_pkg::OP_PUSH: begin res = opnd; push = 1; end
                rsm_pkg::OP_LOAD: begin
                    if (opnd >= VARS) err = rsm_pkg::ERR_INDEX;
                    else if (!var_set[opnd[VAW-1:0]]) err = rsm_pkg::ERR_UNDEF;
                    else begin res = var_mem[opnd[VAW-1:0]]; push = 1; end
                end
                rsm_pkg::OP_NOT: begin res = 32'(y == 0); push = 1; end
                rsm_pkg::OP_OR:  begin res = 32'(x != 0 || y != 0); push = 1; end
                rsm_pkg::OP_AND: begin res = 32'(x != 0 && y != 0); push = 1; end
                rsm_pkg::OP_GO: begin
                    if (y > 32'hFFFF) err = rsm_pkg::ERR_INDEX;
                    else nxt = {1'b0, y[15:0]};
                end
                rsm_pkg::OP_FGO: begin
                    if (x == 0) begin
                        if (y > 32'hFFFF) err = rsm_pkg::ERR_INDEX;
                        else nxt = {1'b0, y[15:0]};
                    end
                end
                rsm_pkg::OP_WRITE: begin wv = 1; wval = y; end
                rsm_pkg::OP_READ: if (y >= VARS) err = rsm_pkg::ERR_INDEX;
                rsm_pkg::OP_ADD: begin res = x + y; push = 1; end
                rsm_pkg::OP_MUL: begin res = x * y; push = 1; end
                rsm_pkg::OP_SUB: begin res = x - y; push = 1; end
                rsm_pkg::OP_DIV: begin
                    if (y == 0) err = rsm_pkg::ERR_DIV0;
                    else if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) begin
                        res = x; push = 1;
                    end else begin
                        res = $signed(x) / $signed(y); push = 1;
                    end
                end
                rsm_pkg::OP_EQ: begin res = 32'(x == y); push = 1; end
                rsm_pkg::OP_LT: begin res = 32'($signed(x) < $signed(y)); push = 1; end
                rsm_pkg::OP_GT: begin res = 32'($signed(x) > $signed(y)); push = 1; end
                rsm_pkg::OP_LE: begin res = 32'($signed(x) <= $signed(y)); push = 1; end
                rsm_pkg::OP_GE: begin res = 32'($signed(x) >= $signed(y)); push = 1; end
                rsm_pkg::OP_NE: begin res = 32'(x != y); push = 1; end
                // assign: x is the index, y the value
                default: if (x >= VARS) err = rsm_pkg::ERR_INDEX;
            endcase
            if (err == rsm_pkg::ERR_OK && push && sp - need >= DEPTH) err = rsm_pkg::ERR_OVER;
        end
        if (err != rsm_pkg::ERR_OK) begin
            nxt = {1'b0, cur}; wv = 0; wval = 0;
        end else begin
            if (op == rsm_pkg::OP_READ) begin
                var_mem[y[VAW-1:0]] = rd; var_set[y[VAW-1:0]] = 1;
            end else if (op == rsm_pkg::OP_ASSIGN) begin
                var_mem[x[VAW-1:0]] = y; var_set[x[VAW-1:0]] = 1;
            end
            sp = sp - need;
            if (push) begin
                stack_mem[SAW'(sp)] = res;
                sp++;
            end
        end
        r.next = nxt[15:0]; r.wvalid = wv; r.wvalue = wval; r.err = err;
        return r;
    endfunction

    assign pending_count = expected_q.size();

    // predict on input transactions, compare on output transactions
    always @(posedge aclk) begin
        step_result_t got, want;
        if (!aresetn) begin
            sp = 0;
            fail_count <= 0;
            for (int i = 0; i < VARS; i++) var_set[i] = 0;
        end else begin
            if (s_tvalid && s_tready) expected_q.push_back(execute_instr(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[51:0];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got.next !== want.next || got.wvalid !== want.wvalid ||
                        got.wvalue !== want.wvalue || got.err !== want.err) begin
                        $display("%0t: mismatch expected next=%h wv=%b wval=%h err=%0d,",
                                 $time, want.next, want.wvalid, want.wvalue, want.err);
                        $display("    actual next=%h wv=%b wval=%h err=%0d",
                                 got.next, got.wvalid, got.wvalue, got.err);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/sv/tb_rpn_stack_machine_step.sv]
// testbench top for the stack machine: stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_rpn_stack_machine_step;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    bit          rx_quiet;
    logic [15:0] pc;

    rpn_stack_machine_step u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    rpn_step_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stalls, drawn per result
    initial begin
        int gap;
        m_tready <= 0;
        @(posedge aclk);
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // one instruction transaction with a random pre-gap; tvalid stays high on return
    task automatic send_instr(input logic [4:0] op, input logic [31:0] opnd,
                              input logic [31:0] rd);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {3'b0, rd, pc, opnd, op};
        pc = $urandom_range(0, 3) == 0 ? 16'hFFFF : pc + 16'd1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 0;
            4: return $urandom_range(0, 5);
            5: return $urandom_range(0, 300);
            6: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [4:0] op;
        rx_quiet = 0;
        pc = 0;
        aresetn <= 0;
        s_tvalid <= 0;
        s_tdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;

        // directed: underflow, bad opcode, undefined, index errors, division corners, reads, writes, jumps
        send_instr(rsm_pkg::OP_ADD, 0, 0);
        send_instr(5'd31, 0, 0);
        send_instr(5'd20, 0, 0);
        send_instr(rsm_pkg::OP_LOAD, 3, 0);
        send_instr(rsm_pkg::OP_LOAD, 32'hFFFF_FFFF, 0);
        send_instr(rsm_pkg::OP_PUSH, 32'h8000_0000, 0);
        send_instr(rsm_pkg::OP_PUSH, 32'hFFFF_FFFF, 0);
        send_instr(rsm_pkg::OP_DIV, 0, 0);
        send_instr(rsm_pkg::OP_PUSH, 0, 0);
        send_instr(rsm_pkg::OP_DIV, 0, 0);
        send_instr(rsm_pkg::OP_PUSH, 7, 0);
        send_instr(rsm_pkg::OP_READ, 0, 32'h7FFF_FFFF);
        send_instr(rsm_pkg::OP_LOAD, 7, 0);
        send_instr(rsm_pkg::OP_WRITE, 0, 0);
        send_instr(rsm_pkg::OP_PUSH, 32'h0001_0000, 0);
        send_instr(rsm_pkg::OP_GO, 0, 0);
        send_instr(rsm_pkg::OP_PUSH, 0, 0);
        send_instr(rsm_pkg::OP_PUSH, 32'h0000_FFFF, 0);
        send_instr(rsm_pkg::OP_FGO, 0, 0);
        send_instr(rsm_pkg::OP_PUSH, 300, 0);
        send_instr(rsm_pkg::OP_READ, 0, 1);
        // overflow: fill the stack past its depth
        for (int i = 0; i < 66; i++) send_instr(rsm_pkg::OP_PUSH, $urandom, 0);
        for (int i = 0; i < 70; i++) send_instr(rsm_pkg::OP_WRITE, 0, 0);
        s_tvalid <= 0;

        // pause until the block has drained
        while (pending_count != 0) @(posedge aclk);

        // random programs, mostly well-formed stack traffic
        for (int i = 0; i < 1350; i++) begin
            if (i == 900) rx_quiet = 1;
            if (i == 1100) rx_quiet = 0;
            case ($urandom_range(0, 9))
                0, 1: send_instr(rsm_pkg::OP_PUSH, rand_val(), $urandom);
                2: send_instr(rsm_pkg::OP_LOAD, $urandom_range(0, 3) == 0 ? rand_val()
                              : $urandom_range(0, 15), $urandom);
                3: begin
                    send_instr(rsm_pkg::OP_PUSH, $urandom_range(0, 3) == 0 ? rand_val()
                               : $urandom_range(0, 15), 0);
                    send_instr(rsm_pkg::OP_READ, $urandom, rand_val());
                end
                4: begin
                    send_instr(rsm_pkg::OP_PUSH, $urandom_range(0, 15), 0);
                    send_instr(rsm_pkg::OP_PUSH, rand_val(), 0);
                    send_instr(rsm_pkg::OP_ASSIGN, $urandom, $urandom);
                end
                5: send_instr(rsm_pkg::OP_WRITE, $urandom, $urandom);
                6: send_instr(5'($urandom_range(0, 31)), $urandom, $urandom);
                default: begin
                    op = 5'($urandom_range(rsm_pkg::OP_NOT, rsm_pkg::OP_ASSIGN));
                    send_instr(op, $urandom, $urandom);
                end
            endcase
        end
        s_tvalid <= 0;

        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
